### rtl/sawbc_pkg.sv
// shared types and constants for the set associative write-back cache
`default_nettype none
package sawbc_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned SEED_W  = 16;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'hACE1;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_REFILL = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_RDATA  = 2'd0,
        KIND_WDONE  = 2'd1,
        KIND_WBACK  = 2'd2,
        KIND_REFREQ = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic capture;      // latch input word, start tag row read
        logic resolve;      // hit/victim decision, lfsr step when no way hits or is invalid
        logic inval_victim; // clear valid/dirty of chosen line
        logic wb_read;      // read writeback word wb_idx
        logic beat_write;   // store refill beat
        logic fill_finish;  // set tag, valid, dirty of refilled line
        logic acc_read;     // read pending word after fill or hit
        logic acc_write;    // merge write on pending word
        logic [7:0] wb_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic victim_dirty;
        logic is_write;
        logic last_beat;
    } t_stat;

    function automatic logic [WORD_W-1:0] expand_mask(input logic [MASK_W-1:0] m);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < MASK_W; i++) begin
            r[i*8 +: 8] = {8{m[i]}};
        end
        return r;
    endfunction

    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] l);
        return {l[0] ^ l[2] ^ l[3] ^ l[5], l[SEED_W-1:1]};
    endfunction

endpackage
`default_nettype wire

### rtl/set_assoc_writeback_cache.sv
// top level of the set associative write-back cache
//
// channel | dir | handshake          | payload
// in      | in  | i_valid / o_ready  | action, addr, wdata, byte_mask, fill_word
// out     | out | o_valid / i_ready  | kind, rdata, mem_block, beat_index, mem_word, last
// cfg     | in  | i_cfg_we           | i_cfg_data (lfsr seed)
//
// hit: lookup (registered tag row compare), decide (data read), respond; the result word
// is registered for output and the next input is taken once the controller is back in idle
// miss: a dirty victim is written back before the refill request; each writeback word after
// the first is read in its own state before its output state on the one data store port
// refill beats are stored as taken; the last one then runs the pending access as a hit
// reset is synchronous, active low; valid and dirty flops clear at once, no sweep
// a stalled output holds the controller in its issuing state; input is taken only when idle
`default_nettype none
module set_assoc_writeback_cache #(
    parameter int SET_BITS   = 6,
    parameter int WAY_BITS   = 2,
    parameter int BLOCK_BITS = 5,
    parameter int ADDR_BITS  = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [15:0]            i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire [1:0]             i_action,
    input  wire [ADDR_BITS-1:0]   i_addr,
    input  wire [63:0]            i_wdata,
    input  wire [7:0]             i_byte_mask,
    input  wire [63:0]            i_fill_word,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [1:0]            o_kind,
    output logic [63:0]           o_rdata,
    output logic [ADDR_BITS-BLOCK_BITS-1:0] o_mem_block,
    output logic [1:0]            o_beat_index,
    output logic [63:0]           o_mem_word,
    output logic                  o_last
);
    import sawbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [63:0] rd_word;
    logic [ADDR_BITS-BLOCK_BITS-1:0] vblk, rblk;
    logic load;
    logic use_rd, use_victim, use_req;
    logic [63:0] r_word;
    logic [ADDR_BITS-BLOCK_BITS-1:0] r_vblk, r_rblk;

    sawbc_datapath #(
        .SET_BITS(SET_BITS), .WAY_BITS(WAY_BITS),
        .BLOCK_BITS(BLOCK_BITS), .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we, .i_cfg_data, .i_action, .i_addr, .i_wdata, .i_byte_mask,
        .i_fill_word, .o_rd_word(rd_word), .o_victim_block(vblk), .o_req_block(rblk)
    );

    sawbc_ctrl #(.BLOCK_BITS(BLOCK_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action,
        .o_cmd(cmd), .i_stat(stat),
        .o_valid, .i_ready, .o_kind, .o_beat(o_beat_index), .o_last,
        .o_load(load),
        .o_use_rd(use_rd), .o_use_victim(use_victim), .o_use_req(use_req)
    );

    // output word payload, loaded with the result register and held while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= rd_word;
            r_vblk <= vblk;
            r_rblk <= rblk;
        end
    end

    assign o_rdata     = use_rd ? r_word : '0;
    assign o_mem_word  = use_victim ? r_word : '0;
    assign o_mem_block = use_victim ? r_vblk : (use_req ? r_rblk : '0);
endmodule
`default_nettype wire

### rtl/sawbc_datapath.sv
// tag, state, data stores and pending access registers
`default_nettype none
module sawbc_datapath #(
    parameter int SET_BITS   = 6,
    parameter int WAY_BITS   = 2,
    parameter int BLOCK_BITS = 5,
    parameter int ADDR_BITS  = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire sawbc_pkg::t_cmd          i_cmd,
    output sawbc_pkg::t_stat              o_stat,
    input  wire                           i_cfg_we,
    input  wire [15:0]                    i_cfg_data,
    input  wire [1:0]                     i_action,
    input  wire [ADDR_BITS-1:0]           i_addr,
    input  wire [63:0]                    i_wdata,
    input  wire [7:0]                     i_byte_mask,
    input  wire [63:0]                    i_fill_word,
    output logic [63:0]                   o_rd_word,
    output logic [ADDR_BITS-BLOCK_BITS-1:0] o_victim_block,
    output logic [ADDR_BITS-BLOCK_BITS-1:0] o_req_block
);
    import sawbc_pkg::*;

    localparam int WB       = (BLOCK_BITS > 3) ? BLOCK_BITS - 3 : 1;
    localparam int NWAYS    = 1 << WAY_BITS;
    localparam int NSETS    = 1 << SET_BITS;
    localparam int TAG_W    = ADDR_BITS - BLOCK_BITS - SET_BITS;
    localparam int LINE_W   = SET_BITS + WAY_BITS;
    localparam int WA_W     = LINE_W + BLOCK_BITS - 3;
    localparam int WAB      = (WAY_BITS > 0) ? WAY_BITS : 1;

    // one row per set holds the tags of all ways
    logic [NWAYS*TAG_W-1:0] tag_mem [NSETS];
    logic [63:0]       data_mem [1 << WA_W];
    logic [NSETS*NWAYS-1:0] r_valid, r_dirty;

    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_write;
    logic [63:0]          r_wdata;
    logic [7:0]           r_mask;
    logic [SEED_W-1:0]    r_lfsr;
    logic [WAB-1:0]       r_way;
    logic [WB-1:0]        r_cnt;
    logic [NWAYS*TAG_W-1:0] r_tag_row;
    logic [TAG_W-1:0]     way_tag [NWAYS];
    logic [TAG_W-1:0]     r_vtag;
    logic                 r_hit;
    logic [63:0]          r_rd;

    logic [SET_BITS-1:0]  set_idx;
    logic [TAG_W-1:0]     tag_val;
    logic [WB-1:0]        word_idx;
    logic                 hit_any, inv_any;
    logic [WAB-1:0]       hit_way, inv_way, vic_way;
    logic [SEED_W-1:0]    lfsr_adv;
    logic [LINE_W-1:0]    line_sel;

    assign set_idx  = r_addr[BLOCK_BITS +: SET_BITS];
    assign tag_val  = r_addr[ADDR_BITS-1 -: TAG_W];
    assign word_idx = (BLOCK_BITS > 3) ? r_addr[3 +: WB] : '0;
    assign lfsr_adv = lfsr_next(r_lfsr);

    function automatic logic [LINE_W-1:0] mk_line(input logic [SET_BITS-1:0] s,
                                                  input logic [WAB-1:0] w);
        logic [SET_BITS+WAB-1:0] t;
        t = {s, w};
        return (WAY_BITS > 0) ? LINE_W'(t) : LINE_W'(s);
    endfunction

    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            way_tag[w] = r_tag_row[w*TAG_W +: TAG_W];
        end
    end

    always_comb begin
        hit_any = 1'b0;
        inv_any = 1'b0;
        hit_way = '0;
        inv_way = '0;
        for (int w = NWAYS - 1; w >= 0; w--) begin
            if (r_valid[mk_line(set_idx, WAB'(w))] && way_tag[w] == tag_val) begin
                hit_any = 1'b1;
                hit_way = WAB'(w);
            end
            if (!r_valid[mk_line(set_idx, WAB'(w))]) begin
                inv_any = 1'b1;
                inv_way = WAB'(w);
            end
        end
        vic_way  = inv_any ? inv_way : WAB'(lfsr_adv[WAB-1:0]);
        line_sel = mk_line(set_idx, r_way);
    end

    // tag row read for the set, one way's tag written on fill
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tag_row <= tag_mem[i_addr[BLOCK_BITS +: SET_BITS]];
        end
        if (i_cmd.fill_finish) begin
            for (int w = 0; w < NWAYS; w++) begin
                if (r_way == WAB'(w)) begin
                    tag_mem[set_idx][w*TAG_W +: TAG_W] <= tag_val;
                end
            end
        end
    end

    // data store, one port
    logic [WA_W-1:0] d_addr;
    logic [WB-1:0]   d_word;
    always_comb begin
        if (i_cmd.wb_read) begin
            d_word = i_cmd.wb_idx[WB-1:0];
        end else if (i_cmd.beat_write) begin
            d_word = r_cnt;
        end else begin
            d_word = word_idx;
        end
        d_addr = (BLOCK_BITS > 3) ? WA_W'({line_sel, d_word}) : WA_W'(line_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.beat_write) begin
            data_mem[d_addr] <= i_fill_word;
        end else if (i_cmd.acc_write) begin
            data_mem[d_addr] <= (r_rd & ~expand_mask(r_mask)) | (r_wdata & expand_mask(r_mask));
        end
        // read word held until the next read command
        if (i_cmd.acc_read || i_cmd.wb_read) begin
            r_rd <= data_mem[d_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_lfsr  <= SEED_RESET;
            r_way   <= '0;
            r_cnt   <= '0;
            r_write <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_data == '0) ? SEED_W'(1) : i_cfg_data;
            end else if (i_cmd.resolve && !hit_any && !inv_any) begin
                r_lfsr <= lfsr_adv;
            end
            if (i_cmd.resolve) begin
                r_hit  <= hit_any;
                r_way  <= hit_any ? hit_way : vic_way;
                r_vtag <= way_tag[hit_any ? hit_way : vic_way];
                r_cnt  <= '0;
            end
            if (i_cmd.inval_victim) begin
                r_valid[line_sel] <= 1'b0;
                r_dirty[line_sel] <= 1'b0;
            end
            if (i_cmd.beat_write) begin
                r_cnt <= r_cnt + 1'b1;
            end
            // refilled line is now resident, the pending access runs as a hit
            if (i_cmd.fill_finish) begin
                r_valid[line_sel] <= 1'b1;
                r_dirty[line_sel] <= 1'b0;
                r_hit             <= 1'b1;
            end
            if (i_cmd.acc_write) begin
                r_dirty[line_sel] <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_write <= (i_action == ACT_WRITE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_mask  <= i_byte_mask;
        end
    end

    assign o_stat.hit          = r_hit;
    assign o_stat.victim_dirty = r_valid[line_sel] && r_dirty[line_sel];
    assign o_stat.is_write     = r_write;
    assign o_stat.last_beat    = (r_cnt == {WB{1'b1}}) || (BLOCK_BITS == 3);
    assign o_rd_word      = r_rd;
    assign o_victim_block = {r_vtag, set_idx};
    assign o_req_block    = r_addr[ADDR_BITS-1:BLOCK_BITS];

    property p_cnt_reset;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.resolve |=> r_cnt == '0;
    endproperty
    a_cnt_reset: assert property (p_cnt_reset) else $error("refill count not cleared");
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_finish |=> r_valid[$past(line_sel)])
        else $error("filled line not valid");
    a_write_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_write |=> r_dirty[$past(line_sel)])
        else $error("written line not dirty");
endmodule
`default_nettype wire

### rtl/sawbc_ctrl.sv
// cache controller state machine and result sequencing
`default_nettype none
module sawbc_ctrl #(
    parameter int BLOCK_BITS = 5
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire [1:0]         i_action,
    output sawbc_pkg::t_cmd   o_cmd,
    input  wire sawbc_pkg::t_stat i_stat,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_beat,
    output logic              o_last,
    output logic              o_load,
    output logic              o_use_rd,
    output logic              o_use_victim,
    output logic              o_use_req
);
    import sawbc_pkg::*;

    localparam int NWORDS = 1 << (BLOCK_BITS - 3);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_LOOKUP  = 8'b0000_0010,
        S_DECIDE  = 8'b0000_0100,
        S_WBRD    = 8'b0000_1000,
        S_WBOUT   = 8'b0001_0000,
        S_REQ     = 8'b0010_0000,
        S_WAIT    = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic       r_pending, n_pending;
    logic [7:0] r_wb, n_wb;
    logic       r_ovalid, n_ovalid;
    logic [1:0] r_kind, n_kind;
    logic       r_last, n_last;
    logic [1:0] r_beat, n_beat;
    logic       acc;
    logic       load;

    assign acc = i_valid && o_ready;

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_wb      = r_wb;
        n_ovalid  = r_ovalid;
        n_kind    = r_kind;
        n_last    = r_last;
        n_beat    = r_beat;
        o_cmd     = '0;
        o_cmd.wb_idx = r_wb;
        o_ready   = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (acc) begin
                    if (i_action == ACT_REFILL) begin
                        if (r_pending) begin
                            o_cmd.beat_write = 1'b1;
                            // last beat: line resident, run the access as a hit
                            if (i_stat.last_beat) begin
                                o_cmd.fill_finish = 1'b1;
                                n_pending = 1'b0;
                                n_state = S_DECIDE;
                            end
                        end
                    end else if (i_action != ACT_NONE && !r_pending) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                // compare the registered tags, pick hit or victim way
                o_cmd.resolve = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.hit) begin
                    if (i_stat.is_write) begin
                        o_cmd.acc_write = 1'b0;
                    end
                    o_cmd.acc_read = 1'b1;
                    n_state = S_RESP;
                end else if (i_stat.victim_dirty) begin
                    n_wb = '0;
                    o_cmd.wb_idx = '0;
                    o_cmd.wb_read = 1'b1;
                    n_state = S_WBOUT;
                end else begin
                    n_state = S_REQ;
                end
            end
            S_WBRD: begin
                o_cmd.wb_read = 1'b1;
                n_state = S_WBOUT;
            end
            S_WBOUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_WBACK;
                    n_last   = 1'b0;
                    n_beat   = r_wb[1:0];
                    if (r_wb == 8'(NWORDS - 1)) begin
                        n_state = S_REQ;
                    end else begin
                        n_wb = r_wb + 8'd1;
                        n_state = S_WBRD;
                    end
                end
            end
            S_REQ: begin
                o_cmd.inval_victim = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_kind    = KIND_REFREQ;
                    n_last    = 1'b1;
                    n_beat    = '0;
                    n_pending = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_kind   = i_stat.is_write ? KIND_WDONE : KIND_RDATA;
                    n_last   = 1'b1;
                    n_beat   = '0;
                    o_cmd.acc_write = i_stat.is_write;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_wb      <= '0;
            r_ovalid  <= 1'b0;
            r_kind    <= KIND_RDATA;
            r_last    <= 1'b0;
            r_beat    <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_wb      <= n_wb;
            r_ovalid  <= n_ovalid;
            r_kind    <= n_kind;
            r_last    <= n_last;
            r_beat    <= n_beat;
        end
    end

    // a new result word enters the output register
    assign load = n_ovalid && (!r_ovalid || i_ready);

    // output payload selection, held with the output register
    logic r_use_rd, r_use_victim, r_use_req;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_rd     <= 1'b0;
            r_use_victim <= 1'b0;
            r_use_req    <= 1'b0;
        end else if (load) begin
            r_use_rd     <= (n_kind == KIND_RDATA);
            r_use_victim <= (n_kind == KIND_WBACK);
            r_use_req    <= (n_kind == KIND_REFREQ);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_beat       = r_beat;
    assign o_last       = r_last;
    assign o_load       = load;
    assign o_use_rd     = r_use_rd;
    assign o_use_victim = r_use_victim;
    assign o_use_req    = r_use_req;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_kind))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready)
        else $error("ready while busy");
    a_req_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT && n_state == S_IDLE |=> r_pending)
        else $error("request without pending miss");
endmodule
`default_nettype wire
